@@ src/vertex_transform_perspective_divide_unit_macros.svh @@
// assertion macros shared by the checker
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define VTPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vtpd check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define VTPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vtpd check failed");

`endif

@@ src/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpd_pkg
// types and constants of the vertex transform and perspective divide unit
// ----------------------------------------------------------------------------
package vtpd_pkg;

    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = 32;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // identity matrix in q16.16
    localparam logic [NUM_CFG-1:0][63:0] CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0,                   64'h0001_0000_0000_0000,
        64'h0,                   64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
        logic               clipped;
        logic               last_out;
    } t_out_item;

    // row sums as sign and magnitude, handed from front to back
    typedef struct packed {
        logic [2:0][63:0] nmag;
        logic [2:0]       nneg;
        logic [63:0]      dmag;
        logic             dneg;
        logic             last;
    } t_mid;

    // one stage of the divider pipeline
    typedef struct packed {
        logic [2:0][64:0] rem;
        logic [2:0][31:0] quo;
        logic [2:0][15:0] nlo;
        logic [2:0]       nneg;
        logic [2:0]       nz;
        logic [2:0]       big;
        logic             dneg;
        logic             wz;
        logic [63:0]      dmag;
        logic             last;
    } t_div;

endpackage

@@ src/vtpd_front.sv @@
// ----------------------------------------------------------------------------
// vtpd_front
// matrix registers, coefficient products and exact row sums
// ----------------------------------------------------------------------------
module vtpd_front import vtpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_in_item             i_item,
    output logic                 o_full,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output t_mid                 o_q_data
);

    logic [NUM_CFG-1:0][63:0] r_cfg;
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     r_l1, r_l2, r_l3, r_l4;
    logic signed [63:0]       r_p [4][3];
    logic signed [31:0]       r_c3 [4];
    logic signed [64:0]       r_sa [4];
    logic signed [64:0]       r_sb [4];
    logic signed [65:0]       r_sum [4];
    logic [3:0]               r_neg;
    logic [3:0][63:0]         r_mag;

    logic                     n_en;
    logic signed [31:0]       n_v [3];
    logic signed [63:0]       n_p [4][3];
    logic signed [31:0]       n_c [4][4];

    assign n_en   = !(r_v4 && i_q_full);
    assign o_full = !n_en;
    assign o_q_wr = r_v4 && n_en;

    assign n_v[0] = i_item.in_x;
    assign n_v[1] = i_item.in_y;
    assign n_v[2] = i_item.in_z;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_c[r][c] = (c % 2 == 1) ? $signed(r_cfg[r*2 + c/2][63:32])
                                         : $signed(r_cfg[r*2 + c/2][31:0]);
            end
            for (int c = 0; c < 3; c++) begin
                n_p[r][c] = n_c[r][c] * n_v[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (n_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_l1 <= i_item.last_vertex;
            r_l2 <= r_l1;
            r_l3 <= r_l2;
            r_l4 <= r_l3;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r][c] <= n_p[r][c];
                end
                r_c3[r] <= n_c[r][3];
                // w column term is the coefficient times one
                r_sa[r]  <= 65'(r_p[r][0]) + 65'(r_p[r][1]);
                r_sb[r]  <= 65'(r_p[r][2]) + 65'($signed({r_c3[r], 16'b0}));
                r_sum[r] <= 66'(r_sa[r]) + 66'(r_sb[r]);
                r_neg[r] <= r_sum[r] < 0;
                r_mag[r] <= (r_sum[r] < 0) ? 64'(-r_sum[r]) : 64'(r_sum[r]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            o_q_data.nmag[r] = r_mag[r];
            o_q_data.nneg[r] = r_neg[r];
        end
        o_q_data.dmag = r_mag[3];
        o_q_data.dneg = r_neg[3];
        o_q_data.last = r_l4;
    end

endmodule

@@ src/vtpd_queue.sv @@
// ----------------------------------------------------------------------------
// vtpd_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module vtpd_queue import vtpd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_mid i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_mid o_rdata,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_mid          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          n_wr, n_rd;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign n_wr    = i_wr && !o_full;
    assign n_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (n_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (n_wr && !n_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (n_rd && !n_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/vtpd_back.sv @@
// ----------------------------------------------------------------------------
// vtpd_back
// pipelined q16.16 divide of x, y, z by w with saturation, and result register
// ----------------------------------------------------------------------------
module vtpd_back import vtpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mid      i_q_data,
    input  logic      i_q_empty,
    output logic      o_q_rd,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_out
);

    t_div       r_d  [QUO_BITS+1];
    logic       r_dv [QUO_BITS+1];
    logic       r_ov;
    t_out_item  r_out;

    logic       n_en;
    t_div       n_prep;
    logic [2:0][31:0] n_res;
    logic [2:0] n_clip;

    assign n_en    = !(r_ov && !i_pop);
    assign o_q_rd  = n_en && !i_q_empty;
    assign o_empty = !r_ov;
    assign o_out   = r_out;

    // quotient fits 32 bits only when num < w * 2^16
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_prep.rem[l]  = 65'(i_q_data.nmag[l] >> FRAC_BITS);
            n_prep.quo[l]  = '0;
            n_prep.nlo[l]  = i_q_data.nmag[l][FRAC_BITS-1:0];
            n_prep.nneg[l] = i_q_data.nneg[l];
            n_prep.nz[l]   = i_q_data.nmag[l] != '0;
            n_prep.big[l]  = {16'b0, i_q_data.nmag[l]} >= {i_q_data.dmag, 16'b0};
        end
        n_prep.dneg = i_q_data.dneg;
        n_prep.wz   = i_q_data.dmag == '0;
        n_prep.dmag = i_q_data.dmag;
        n_prep.last = i_q_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (n_en) begin
            r_dv[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d[0] <= n_prep;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
        localparam int B = QUO_BITS - k;
        t_div n_st;

        always_comb begin
            n_st = r_d[k-1];
            for (int l = 0; l < 3; l++) begin
                logic [64:0] t;
                logic        ge;
                t  = {r_d[k-1].rem[l][63:0],
                      (B >= FRAC_BITS) ? r_d[k-1].nlo[l][(B % FRAC_BITS)] : 1'b0};
                ge = t >= {1'b0, r_d[k-1].dmag};
                n_st.rem[l] = ge ? t - {1'b0, r_d[k-1].dmag} : t;
                n_st.quo[l] = {r_d[k-1].quo[l][30:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (n_en) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (n_en) begin
                r_d[k] <= n_st;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic qneg;
            logic [31:0] q;
            qneg = r_d[QUO_BITS].nneg[l] ^ r_d[QUO_BITS].dneg;
            q    = r_d[QUO_BITS].quo[l];
            n_clip[l] = 1'b0;
            if (r_d[QUO_BITS].wz) begin
                n_res[l] = !r_d[QUO_BITS].nz[l] ? 32'h0
                         : (r_d[QUO_BITS].nneg[l] ? SAT_NEG : SAT_POS);
            end else if (r_d[QUO_BITS].big[l]) begin
                n_clip[l] = 1'b1;
                n_res[l]  = qneg ? SAT_NEG : SAT_POS;
            end else if (qneg) begin
                n_clip[l] = q > SAT_NEG;
                n_res[l]  = (q > SAT_NEG) ? SAT_NEG : 32'(-q);
            end else begin
                n_clip[l] = q > SAT_POS;
                n_res[l]  = (q > SAT_POS) ? SAT_POS : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_ov <= r_dv[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out.out_x    <= n_res[0];
            r_out.out_y    <= n_res[1];
            r_out.out_z    <= n_res[2];
            r_out.w_zero   <= r_d[QUO_BITS].wz;
            r_out.clipped  <= |n_clip;
            r_out.last_out <= r_d[QUO_BITS].last;
        end
    end

endmodule

@@ src/vertex_transform_perspective_divide_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit
// 4x4 q16.16 matrix transform of (x, y, z, 1) followed by divide by w
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   input    | push / full        | i_in  (t_in_item)
//   result   | empty / pop        | o_out (t_out_item)
//   config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one vertex per cycle unless a held result stalls; front, then queue, then back
// latency is set by the one-bit-per-stage divider pipeline of 32 stages
// synchronous reset clears valids, queue pointers and loads the identity matrix
// a held result stalls the back; the front keeps taking beats until the queue fills
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_unit import vtpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    logic q_wr, q_full, q_rd, q_empty;
    t_mid q_wdata, q_rdata;

    vtpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in),
        .o_full     (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_q_data   (q_wdata)
    );

    vtpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    vtpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ src/vtpd_checker.sv @@
// ----------------------------------------------------------------------------
// vtpd_checker
// port-level checks of the vertex transform unit, bound to the top level
// ----------------------------------------------------------------------------
`include "vertex_transform_perspective_divide_unit_macros.svh"

module vtpd_checker import vtpd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out
);

    logic n_any_sat;

    assign n_any_sat = o_out.out_x == SAT_POS || o_out.out_x == SAT_NEG ||
                       o_out.out_y == SAT_POS || o_out.out_y == SAT_NEG ||
                       o_out.out_z == SAT_POS || o_out.out_z == SAT_NEG;

    // a waiting result stays until popped
    `VTPD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_out))

    // zero w saturates by numerator sign (zero over zero gives zero) and never counts as clipping
    `VTPD_ASSERT_NOW(a_wz_no_clip, !empty && o_out.w_zero, !o_out.clipped)

    // a clipped beat carries at least one saturated coordinate
    `VTPD_ASSERT_NOW(a_clip_sat, !empty && o_out.clipped, n_any_sat)

endmodule

bind vertex_transform_perspective_divide_unit vtpd_checker u_vtpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);
